// ===== rtl/srs_pkg.sv =====
// Shared types, constants and register codes for the servo ramp stepper.
package srs_pkg;

   localparam int ANGLE_W     = 8;
   localparam int STEP_W      = 5;
   localparam int PWM_W       = 12;
   localparam int CHANNEL_W   = 4;
   localparam int NUM_JOINTS  = 3;
   localparam int JOINT_IDX_W = 2;

   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 24;

   localparam int DEF_FIRST_CHANNEL = 9;
   localparam int DEF_QUEUE_DEPTH   = 4;

   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_SIZE  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PWM_MIN    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PWM_MAX    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRIP_CLOSE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRIP_OPEN  = 3'd4;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [ANGLE_W-1:0]     ANGLE_MAX   = 8'd180;
   localparam logic [JOINT_IDX_W-1:0] GRIP_INDEX  = 2'd3;

   localparam logic [STEP_W-1:0]  RST_STEP_SIZE  = 5'd2;
   localparam logic [PWM_W-1:0]   RST_PWM_MIN    = 12'd150;
   localparam logic [PWM_W-1:0]   RST_PWM_MAX    = 12'd600;
   localparam logic [ANGLE_W-1:0] RST_GRIP_CLOSE = 8'd120;
   localparam logic [ANGLE_W-1:0] RST_GRIP_OPEN  = 8'd30;
   localparam logic [ANGLE_W-1:0] RST_GRIP_ANGLE = 8'd30;
   localparam logic [NUM_JOINTS-1:0][ANGLE_W-1:0] RST_JOINT_ANGLE = {8'd10, 8'd60, 8'd60};

   // Floor division by 180 through a scaled reciprocal, exact for magnitudes below 2^20.
   localparam int PRODUCT_W   = 21;
   localparam int MAG_W       = 20;
   localparam int RECIP_W     = 21;
   localparam int RECIP_SHIFT = 28;
   localparam logic [RECIP_W-1:0] RECIP_180      = 21'd1491309;
   localparam logic [MAG_W-1:0]   FLOOR_BIAS_180 = 20'd179;

   typedef struct packed {
      logic [STEP_W-1:0]  step_size;
      logic [PWM_W-1:0]   pwm_min;
      logic [PWM_W-1:0]   pwm_max;
      logic [ANGLE_W-1:0] grip_close_limit;
      logic [ANGLE_W-1:0] grip_open_limit;
   } cfg_type;

   typedef struct packed {
      logic [ANGLE_W-1:0]     angle;
      logic [JOINT_IDX_W-1:0] joint;
      logic                   write_valid;
      logic                   move_done;
      logic                   last;
   } entry_type;

endpackage

// ===== rtl/srs_queue.sv =====
// Small FIFO of write commands between the move sequencer and the PWM mapper.
module srs_queue import srs_pkg::*; #(
   parameter int DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output entry_type pop_entry,
   output logic      empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign pop_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/srs_front.sv =====
// Move sequencer: takes load and tick beats, steps the joints and gripper, queues writes.
module srs_front import srs_pkg::*; (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cfg_type                              cfg,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_op,
   input  logic [NUM_JOINTS-1:0][ANGLE_W-1:0]   req_target,
   input  logic                                 req_grab,
   output logic                                 push,
   output entry_type                            push_entry,
   input  logic                                 queue_full
);

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_JOINT = 2'd1;
   localparam logic [1:0] PH_GRIP  = 2'd2;

   logic [NUM_JOINTS-1:0][ANGLE_W-1:0] joint_angle_ff, joint_angle_in;
   logic [NUM_JOINTS-1:0][ANGLE_W-1:0] joint_target_ff, joint_target_in;
   logic [ANGLE_W-1:0] grip_angle_ff, grip_angle_in;
   logic [ANGLE_W-1:0] cursor_ff, cursor_in;
   logic               grab_mode_ff, grab_mode_in;
   logic [1:0]         phase_ff, phase_in;
   logic [NUM_JOINTS-1:0] pend_valid_ff, pend_valid_in;
   entry_type             pend_entry_ff [NUM_JOINTS];
   entry_type             pend_entry_in [NUM_JOINTS];

   logic [ANGLE_W-1:0]     step;
   logic [NUM_JOINTS-1:0]  moves;
   logic [NUM_JOINTS-1:0][ANGLE_W-1:0] stepped;
   logic [ANGLE_W-1:0]     gap;
   logic [ANGLE_W:0]       cursor_sum;
   logic [ANGLE_W-1:0]     cursor_next;
   logic [JOINT_IDX_W-1:0] sel;
   logic [NUM_JOINTS-1:0]  remaining;
   logic                   accept;
   entry_type              idle_entry;

   function automatic logic grip_done(input logic mode, input logic [ANGLE_W-1:0] c,
                                      input logic [ANGLE_W-1:0] close_lim,
                                      input logic [ANGLE_W-1:0] open_lim);
      return mode ? (c >= close_lim) : (c <= open_lim);
   endfunction

   always_comb begin
      step = (cfg.step_size == '0) ? 8'd1 : {3'b000, cfg.step_size};
      gap = '0;
      for (int i = 0; i < NUM_JOINTS; i++) begin
         gap = (joint_angle_ff[i] > joint_target_ff[i]) ?
               joint_angle_ff[i] - joint_target_ff[i] : joint_target_ff[i] - joint_angle_ff[i];
         moves[i]   = (gap >= step);
         stepped[i] = (joint_target_ff[i] < joint_angle_ff[i]) ?
                      joint_angle_ff[i] - step : joint_angle_ff[i] + step;
      end

      cursor_sum = {1'b0, cursor_ff} + {1'b0, step};
      if (grab_mode_ff) begin
         cursor_next = cursor_sum[ANGLE_W] ? '1 : cursor_sum[ANGLE_W-1:0];
      end else begin
         cursor_next = (cursor_ff < step) ? '0 : cursor_ff - step;
      end

      // Drain the lowest pending slot first so joint writes leave in joint order.
      sel = '0;
      for (int i = NUM_JOINTS - 1; i >= 0; i--) begin
         if (pend_valid_ff[i]) begin
            sel = JOINT_IDX_W'(i);
         end
      end
      push       = (pend_valid_ff != '0) && !queue_full;
      push_entry = pend_entry_ff[sel];
      remaining  = pend_valid_ff;
      if (push) begin
         remaining[sel] = 1'b0;
      end
      req_ready = (remaining == '0);
      accept    = req_valid && req_ready;

      idle_entry = '{angle: '0, joint: '0, write_valid: 1'b0, move_done: 1'b1, last: 1'b1};

      joint_angle_in  = joint_angle_ff;
      joint_target_in = joint_target_ff;
      grip_angle_in   = grip_angle_ff;
      cursor_in       = cursor_ff;
      grab_mode_in    = grab_mode_ff;
      phase_in        = phase_ff;
      pend_valid_in   = remaining;
      for (int i = 0; i < NUM_JOINTS; i++) begin
         pend_entry_in[i] = pend_entry_ff[i];
      end

      if (accept) begin
         if (req_op == OP_LOAD) begin
            for (int i = 0; i < NUM_JOINTS; i++) begin
               joint_target_in[i] = (req_target[i] > ANGLE_MAX) ? ANGLE_MAX : req_target[i];
            end
            grab_mode_in = req_grab;
            phase_in     = PH_JOINT;
         end else begin
            case (phase_ff)
               PH_JOINT: begin
                  if (moves != '0) begin
                     pend_valid_in = moves;
                     for (int i = 0; i < NUM_JOINTS; i++) begin
                        if (moves[i]) begin
                           joint_angle_in[i] = stepped[i];
                        end
                        pend_entry_in[i] = '{angle: stepped[i], joint: JOINT_IDX_W'(i),
                                             write_valid: 1'b1, move_done: 1'b0,
                                             last: ((moves >> (i + 1)) == '0)};
                     end
                  end else begin
                     cursor_in = grip_angle_ff;
                     pend_valid_in = 3'b001;
                     pend_entry_in[0] = idle_entry;
                     if (grip_done(grab_mode_ff, grip_angle_ff, cfg.grip_close_limit,
                                   cfg.grip_open_limit)) begin
                        phase_in = PH_IDLE;
                     end else begin
                        phase_in = PH_GRIP;
                        pend_entry_in[0].move_done = 1'b0;
                     end
                  end
               end
               PH_GRIP: begin
                  pend_valid_in = 3'b001;
                  if (grip_done(grab_mode_ff, cursor_ff, cfg.grip_close_limit,
                                cfg.grip_open_limit)) begin
                     phase_in = PH_IDLE;
                     pend_entry_in[0] = idle_entry;
                  end else begin
                     grip_angle_in = cursor_ff;
                     cursor_in     = cursor_next;
                     pend_entry_in[0] = '{angle: cursor_ff, joint: GRIP_INDEX,
                                          write_valid: 1'b1, move_done: 1'b0, last: 1'b1};
                     if (grip_done(grab_mode_ff, cursor_next, cfg.grip_close_limit,
                                   cfg.grip_open_limit)) begin
                        phase_in = PH_IDLE;
                        pend_entry_in[0].move_done = 1'b1;
                     end
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
                  pend_valid_in = 3'b001;
                  pend_entry_in[0] = idle_entry;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         joint_angle_ff  <= RST_JOINT_ANGLE;
         joint_target_ff <= '0;
         grip_angle_ff   <= RST_GRIP_ANGLE;
         cursor_ff       <= '0;
         grab_mode_ff    <= 1'b0;
         phase_ff        <= PH_IDLE;
         pend_valid_ff   <= '0;
      end else begin
         joint_angle_ff  <= joint_angle_in;
         joint_target_ff <= joint_target_in;
         grip_angle_ff   <= grip_angle_in;
         cursor_ff       <= cursor_in;
         grab_mode_ff    <= grab_mode_in;
         phase_ff        <= phase_in;
         pend_valid_ff   <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_JOINTS; i++) begin
         pend_entry_ff[i] <= pend_entry_in[i];
      end
   end

endmodule

// ===== rtl/srs_back.sv =====
// PWM mapper: turns queued angles into channel and PWM count beats, three-stage pipeline.
module srs_back import srs_pkg::*; #(
   parameter int FIRST_CHANNEL = DEF_FIRST_CHANNEL
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 queue_empty,
   input  entry_type            queue_entry,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [CHANNEL_W-1:0] rsp_channel,
   output logic [PWM_W-1:0]     rsp_pwm,
   output logic                 rsp_write_valid,
   output logic                 rsp_done,
   output logic                 rsp_last
);

   logic                 advance;
   logic                 s1_valid_ff, s2_valid_ff, out_valid_ff;
   entry_type            s1_entry_ff, s2_entry_ff;
   logic [PRODUCT_W-1:0] s1_prod_ff, s1_prod_in;
   logic                 s2_neg_ff, s2_neg_in;
   logic [PWM_W-1:0]     s2_quot_ff, s2_quot_in;
   logic [CHANNEL_W-1:0] channel_ff, channel_in;
   logic [PWM_W-1:0]     pwm_ff, pwm_in;
   logic                 wv_ff, done_ff, last_ff;

   logic [ANGLE_W-1:0]             angle_sat;
   logic signed [PWM_W:0]          span;
   logic signed [PRODUCT_W:0]      prod_full;
   logic [PRODUCT_W-1:0]           prod_abs;
   logic [MAG_W-1:0]               biased;
   logic [MAG_W+RECIP_W-1:0]       quot_full;

   assign advance = !out_valid_ff || rsp_ready;
   assign pop     = advance && !queue_empty;

   always_comb begin
      // Stage 1: angle times signed PWM span.
      angle_sat  = (queue_entry.angle > ANGLE_MAX) ? ANGLE_MAX : queue_entry.angle;
      span       = $signed({1'b0, cfg.pwm_max}) - $signed({1'b0, cfg.pwm_min});
      prod_full  = $signed({1'b0, angle_sat}) * span;
      s1_prod_in = prod_full[PRODUCT_W-1:0];

      // Stage 2: floor division by 180; a negative product rounds its magnitude up.
      s2_neg_in = s1_prod_ff[PRODUCT_W-1];
      prod_abs  = s2_neg_in ? (~s1_prod_ff + 1'b1) : s1_prod_ff;
      biased    = prod_abs[MAG_W-1:0] + (s2_neg_in ? FLOOR_BIAS_180 : '0);
      quot_full = biased * RECIP_180;
      s2_quot_in = quot_full[RECIP_SHIFT +: PWM_W];

      // Stage 3: offset by the zero-degree count.
      pwm_in     = s2_neg_ff ? cfg.pwm_min - s2_quot_ff : cfg.pwm_min + s2_quot_ff;
      channel_in = CHANNEL_W'(FIRST_CHANNEL) + {{(CHANNEL_W-JOINT_IDX_W){1'b0}}, s2_entry_ff.joint};
      if (!s2_entry_ff.write_valid) begin
         pwm_in     = '0;
         channel_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= !queue_empty;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_entry_ff <= queue_entry;
         s1_prod_ff  <= s1_prod_in;
         s2_entry_ff <= s1_entry_ff;
         s2_neg_ff   <= s2_neg_in;
         s2_quot_ff  <= s2_quot_in;
         channel_ff  <= channel_in;
         pwm_ff      <= pwm_in;
         wv_ff       <= s2_entry_ff.write_valid;
         done_ff     <= s2_entry_ff.move_done;
         last_ff     <= s2_entry_ff.last;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_channel     = channel_ff;
   assign rsp_pwm         = pwm_ff;
   assign rsp_write_valid = wv_ff;
   assign rsp_done        = done_ff;
   assign rsp_last        = last_ff;

endmodule

// ===== rtl/servo_ramp_stepper.sv =====
// Throughput: one result beat per cycle while rsp_tready is high; a tick that moves several
// joints holds the sequencer until its writes have drained into the queue, one per cycle
// while the queue is not full; a load leaves nothing pending, so the sequencer stays ready.
// Reset is synchronous and active high; it restores control state and configuration at once,
// with no clearing pass; queue storage and pipeline data registers are not reset.
module servo_ramp_stepper import srs_pkg::*; #(
   parameter int FIRST_CHANNEL = DEF_FIRST_CHANNEL,
   parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // target_base[7:0], target_shoulder[15:8], target_elbow[23:16], grab[24], zero fill
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // operation[0]
   input  logic [0:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // channel[3:0], pwm_value[15:4], move_done[16], zero fill
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // write_valid[0]
   output logic [0:0]             rsp_tuser,
   output logic                   rsp_tlast,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [PWM_W-1:0]       csr_wdata
);

   cfg_type cfg_ff, cfg_in;

   logic [NUM_JOINTS-1:0][ANGLE_W-1:0] targets;
   logic                 push, queue_full, queue_empty, pop;
   entry_type            push_entry, pop_entry;
   logic [CHANNEL_W-1:0] channel;
   logic [PWM_W-1:0]     pwm;
   logic                 write_valid, done;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_STEP_SIZE:  cfg_in.step_size        = csr_wdata[STEP_W-1:0];
            CSR_PWM_MIN:    cfg_in.pwm_min          = csr_wdata;
            CSR_PWM_MAX:    cfg_in.pwm_max          = csr_wdata;
            CSR_GRIP_CLOSE: cfg_in.grip_close_limit = csr_wdata[ANGLE_W-1:0];
            CSR_GRIP_OPEN:  cfg_in.grip_open_limit  = csr_wdata[ANGLE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{step_size: RST_STEP_SIZE, pwm_min: RST_PWM_MIN, pwm_max: RST_PWM_MAX,
                     grip_close_limit: RST_GRIP_CLOSE, grip_open_limit: RST_GRIP_OPEN};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign targets = req_tdata[NUM_JOINTS*ANGLE_W-1:0];

   srs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_op     (req_tuser[0]),
      .req_target (targets),
      .req_grab   (req_tdata[NUM_JOINTS*ANGLE_W]),
      .push       (push),
      .push_entry (push_entry),
      .queue_full (queue_full)
   );

   srs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .empty      (queue_empty)
   );

   srs_back #(.FIRST_CHANNEL(FIRST_CHANNEL)) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .queue_empty     (queue_empty),
      .queue_entry     (pop_entry),
      .pop             (pop),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_channel     (channel),
      .rsp_pwm         (pwm),
      .rsp_write_valid (write_valid),
      .rsp_done        (done),
      .rsp_last        (rsp_tlast)
   );

   assign rsp_tdata = {{(RSP_TDATA_W-CHANNEL_W-PWM_W-1){1'b0}}, done, pwm, channel};
   assign rsp_tuser = write_valid;

endmodule

// ===== rtl/srs_checker.sv =====
// Port-level checks on the result stream of the servo ramp stepper, with its bind.
module srs_checker import srs_pkg::*; #(
   parameter int FIRST_CHANNEL = DEF_FIRST_CHANNEL
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [0:0]             rsp_tuser,
   input logic                   rsp_tlast
);

   localparam logic [CHANNEL_W-1:0] CH_LO = CHANNEL_W'(FIRST_CHANNEL);
   localparam logic [CHANNEL_W-1:0] CH_HI = CHANNEL_W'(FIRST_CHANNEL + 3);

   // A stalled result beat keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // A beat without a servo write is always the single, final beat of its tick.
   a_nowrite_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast && (rsp_tdata[CHANNEL_W+PWM_W-1:0] == '0))
      else $error("non-write beat carries channel or PWM data or is not last");

   // Completion is only ever reported on the final beat of a tick.
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[CHANNEL_W+PWM_W] |-> rsp_tlast)
      else $error("move done reported on a beat that is not last");

   // Writes go only to the arm's four servo channels.
   a_channel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
      (rsp_tdata[CHANNEL_W-1:0] >= CH_LO) && (rsp_tdata[CHANNEL_W-1:0] <= CH_HI))
      else $error("servo write to a channel outside the arm");

endmodule

bind servo_ramp_stepper srs_checker #(.FIRST_CHANNEL(FIRST_CHANNEL)) u_srs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== tb/servo_ramp_stepper_checker.sv =====
// Beat checker for the servo ramp stepper: predicts every result beat and compares it.
module servo_ramp_stepper_checker import srs_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [0:0]             req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic [0:0]             rsp_tuser,
   input  logic                   rsp_tlast,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [PWM_W-1:0]       csr_wdata,
   output int                     mismatches,
   output int                     pending,
   output int                     results_checked
);

   localparam int FIRST_CH   = DEF_FIRST_CHANNEL;
   localparam int ANGLE_CEIL = (1 << ANGLE_W) - 1;

   typedef enum logic [1:0] {ARM_IDLE, ARM_JOINTS, ARM_GRIPPER} arm_phase_type;

   typedef struct packed {
      logic [CHANNEL_W-1:0] channel;
      logic [PWM_W-1:0]     pwm;
      logic                 write_valid;
      logic                 move_done;
      logic                 last;
   } servo_beat_type;

   logic [STEP_W-1:0]  step_reg;
   logic [PWM_W-1:0]   pwm_lo_reg;
   logic [PWM_W-1:0]   pwm_hi_reg;
   logic [ANGLE_W-1:0] close_reg;
   logic [ANGLE_W-1:0] open_reg;

   logic [ANGLE_W-1:0] angle_q  [NUM_JOINTS];
   logic [ANGLE_W-1:0] target_q [NUM_JOINTS];
   logic [ANGLE_W-1:0] grip_angle_q;
   logic [ANGLE_W-1:0] grip_cursor_q;
   logic               grab_q;
   arm_phase_type      phase_q;

   servo_beat_type servo_beats[$];

   // Floor division keeps the count between the two end points even when pwm_max < pwm_min.
   function automatic logic [PWM_W-1:0] angle_to_pwm(input logic [ANGLE_W-1:0] angle);
      int a;
      int span;
      int prod;
      int quot;
      int total;
      a = (angle > ANGLE_MAX) ? int'(ANGLE_MAX) : int'(angle);
      span = int'(pwm_hi_reg) - int'(pwm_lo_reg);
      prod = a * span;
      quot = prod / int'(ANGLE_MAX);
      if (prod < 0 && (prod % int'(ANGLE_MAX)) != 0)
         quot = quot - 1;
      total = int'(pwm_lo_reg) + quot;
      return total[PWM_W-1:0];
   endfunction

   function automatic logic grip_done(input logic [ANGLE_W-1:0] cursor);
      return grab_q ? (cursor >= close_reg) : (cursor <= open_reg);
   endfunction

   function automatic void push_beat(input int ch, input logic [PWM_W-1:0] pwm,
                                     input logic wv, input logic done, input logic last);
      servo_beat_type b;
      b.channel     = ch[CHANNEL_W-1:0];
      b.pwm         = pwm;
      b.write_valid = wv;
      b.move_done   = done;
      b.last        = last;
      servo_beats.push_back(b);
   endfunction

   task automatic predict_servo_writes(input logic op, input logic [REQ_TDATA_W-1:0] data);
      int                 stride;
      int                 moved;
      int                 cur;
      int                 tgt;
      int                 gap;
      int                 nxt;
      int                 ch [NUM_JOINTS];
      logic [ANGLE_W-1:0] t;
      logic               fin;
      stride = (step_reg == '0) ? 1 : int'(step_reg);
      if (op == OP_LOAD) begin
         for (int j = 0; j < NUM_JOINTS; j++) begin
            t = data[j*ANGLE_W +: ANGLE_W];
            target_q[j] = (t > ANGLE_MAX) ? ANGLE_MAX : t;
         end
         grab_q = data[NUM_JOINTS*ANGLE_W];
         phase_q = ARM_JOINTS;
      end else if (phase_q == ARM_JOINTS) begin
         moved = 0;
         for (int j = 0; j < NUM_JOINTS; j++) begin
            cur = int'(angle_q[j]);
            tgt = int'(target_q[j]);
            gap = (cur > tgt) ? cur - tgt : tgt - cur;
            if (gap >= stride) begin
               nxt = (tgt < cur) ? cur - stride : cur + stride;
               angle_q[j] = nxt[ANGLE_W-1:0];
               ch[moved] = j;
               moved++;
            end
         end
         for (int k = 0; k < moved; k++)
            push_beat(FIRST_CH + ch[k], angle_to_pwm(angle_q[ch[k]]), 1'b1, 1'b0,
                      k == moved - 1);
         if (moved == 0) begin
            // The joints have arrived: the gripper starts from where it was last written.
            phase_q = ARM_GRIPPER;
            grip_cursor_q = grip_angle_q;
            fin = grip_done(grip_cursor_q);
            if (fin)
               phase_q = ARM_IDLE;
            push_beat(0, '0, 1'b0, fin, 1'b1);
         end
      end else if (phase_q == ARM_GRIPPER) begin
         if (grip_done(grip_cursor_q)) begin
            phase_q = ARM_IDLE;
            push_beat(0, '0, 1'b0, 1'b1, 1'b1);
         end else begin
            grip_angle_q = grip_cursor_q;
            cur = int'(grip_cursor_q);
            if (grab_q)
               nxt = (cur + stride > ANGLE_CEIL) ? ANGLE_CEIL : cur + stride;
            else
               nxt = (cur < stride) ? 0 : cur - stride;
            grip_cursor_q = nxt[ANGLE_W-1:0];
            fin = grip_done(grip_cursor_q);
            if (fin)
               phase_q = ARM_IDLE;
            push_beat(FIRST_CH + int'(GRIP_INDEX), angle_to_pwm(grip_angle_q), 1'b1, fin, 1'b1);
         end
      end else begin
         phase_q = ARM_IDLE;
         push_beat(0, '0, 1'b0, 1'b1, 1'b1);
      end
   endtask

   always @(posedge clock) begin
      servo_beat_type got;
      servo_beat_type want;
      if (reset) begin
         step_reg      = RST_STEP_SIZE;
         pwm_lo_reg    = RST_PWM_MIN;
         pwm_hi_reg    = RST_PWM_MAX;
         close_reg     = RST_GRIP_CLOSE;
         open_reg      = RST_GRIP_OPEN;
         for (int j = 0; j < NUM_JOINTS; j++) begin
            angle_q[j]  = RST_JOINT_ANGLE[j];
            target_q[j] = '0;
         end
         grip_angle_q  = RST_GRIP_ANGLE;
         grip_cursor_q = '0;
         grab_q        = 1'b0;
         phase_q       = ARM_IDLE;
         servo_beats.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_STEP_SIZE:  step_reg   = csr_wdata[STEP_W-1:0];
               CSR_PWM_MIN:    pwm_lo_reg = csr_wdata;
               CSR_PWM_MAX:    pwm_hi_reg = csr_wdata;
               CSR_GRIP_CLOSE: close_reg  = csr_wdata[ANGLE_W-1:0];
               CSR_GRIP_OPEN:  open_reg   = csr_wdata[ANGLE_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            predict_servo_writes(req_tuser[0], req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got.channel     = rsp_tdata[CHANNEL_W-1:0];
            got.pwm         = rsp_tdata[CHANNEL_W +: PWM_W];
            got.move_done   = rsp_tdata[CHANNEL_W+PWM_W];
            got.write_valid = rsp_tuser[0];
            got.last        = rsp_tlast;
            if (servo_beats.size() == 0) begin
               mismatches++;
               $display("%0t: result beat with nothing expected", $time);
               $display("   actual   ch=%0d pwm=%0d wv=%b done=%b last=%b",
                        got.channel, got.pwm, got.write_valid, got.move_done, got.last);
            end else begin
               want = servo_beats.pop_front();
               results_checked++;
               if (got !== want) begin
                  mismatches++;
                  $display("%0t: result beat mismatch", $time);
                  $display("   expected ch=%0d pwm=%0d wv=%b done=%b last=%b",
                           want.channel, want.pwm, want.write_valid, want.move_done, want.last);
                  $display("   actual   ch=%0d pwm=%0d wv=%b done=%b last=%b",
                           got.channel, got.pwm, got.write_valid, got.move_done, got.last);
               end
            end
         end
      end
      pending = servo_beats.size();
   end

endmodule

// ===== tb/tb_servo_ramp_stepper.sv =====
// Testbench top for the servo ramp stepper: clock, reset, stimulus, stalls and verdict.
module tb_servo_ramp_stepper;
   import srs_pkg::*;

   // Longest quiet stretch expected: the output hold below plus a few long random stalls.
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 150;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd5;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [0:0]             req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [0:0]             rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [PWM_W-1:0]       csr_wdata  = '0;

   int mismatches;
   int pending;
   int results_checked;

   int          idle_mode    = 0;
   logic        hold_request = 1'b0;
   logic        hold_served  = 1'b0;
   int          hold_left    = 0;
   int          quiet_cycles = 0;
   int          loads_sent   = 0;
   int          ticks_sent   = 0;
   int          reg_writes   = 0;
   int          step_now     = int'(RST_STEP_SIZE);

   servo_ramp_stepper u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   servo_ramp_stepper_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatches      (mismatches),
      .pending         (pending),
      .results_checked (results_checked)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Output side: random stalls, plus one long hold that lets the block back up.
   always @(negedge clock) begin
      int pct;
      pct = (idle_mode == 0) ? 83 : (idle_mode == 1) ? 37 : 0;
      if (hold_request && !hold_served) begin
         hold_served = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, pending);
            $display("[servo_ramp_stepper] ERROR");
            $finish;
         end
      end
   end

   function automatic logic [ANGLE_W-1:0] pick_angle();
      int a;
      if ($urandom_range(9) == 0)
         a = $urandom_range(int'(ANGLE_MAX) + 1, (1 << ANGLE_W) - 1);
      else
         a = $urandom_range(0, int'(ANGLE_MAX));
      return a[ANGLE_W-1:0];
   endfunction

   task automatic send_beat(input logic op, input logic [ANGLE_W-1:0] base,
                            input logic [ANGLE_W-1:0] shoulder, input logic [ANGLE_W-1:0] elbow,
                            input logic grab);
      int                     pct;
      logic [REQ_TDATA_W-1:0] word;
      pct = (idle_mode == 0) ? 37 : (idle_mode == 1) ? 83 : 0;
      while ($urandom_range(99) < pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      word = '0;
      word[0 +: ANGLE_W]         = base;
      word[ANGLE_W +: ANGLE_W]   = shoulder;
      word[2*ANGLE_W +: ANGLE_W] = elbow;
      word[3*ANGLE_W]            = grab;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
      if (op == OP_LOAD)
         loads_sent++;
      else
         ticks_sent++;
   endtask

   task automatic send_tick();
      send_beat(OP_TICK, pick_angle(), pick_angle(), pick_angle(), 1'($urandom_range(1)));
   endtask

   // Called only after settle, so the block has no work in flight.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [PWM_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      reg_writes++;
      if (idx == CSR_STEP_SIZE)
         step_now = int'(value[STEP_W-1:0]);
   endtask

   task automatic configure(input int step, input int lo, input int hi,
                            input int close_lim, input int open_lim);
      write_reg(CSR_STEP_SIZE, step[PWM_W-1:0]);
      write_reg(CSR_PWM_MIN, lo[PWM_W-1:0]);
      write_reg(CSR_PWM_MAX, hi[PWM_W-1:0]);
      write_reg(CSR_GRIP_CLOSE, close_lim[PWM_W-1:0]);
      write_reg(CSR_GRIP_OPEN, open_lim[PWM_W-1:0]);
      write_reg(CSR_SPARE_LO + CSR_INDEX_W'($urandom_range(2)),
                PWM_W'($urandom_range((1 << PWM_W) - 1)));
   endtask

   // Loads never answer, so a wait after the last result covers a load still in flight.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic run_move(input logic [ANGLE_W-1:0] base, input logic [ANGLE_W-1:0] shoulder,
                           input logic [ANGLE_W-1:0] elbow, input logic grab, input int ticks);
      send_beat(OP_LOAD, base, shoulder, elbow, grab);
      repeat (ticks) send_tick();
   endtask

   // Mostly whole moves with random targets; the rest stray ticks and loads that cut a move short.
   task automatic random_phase(input int beats);
      int sent;
      int kind;
      int stride;
      int ticks;
      sent = 0;
      while (sent < beats) begin
         kind = $urandom_range(99);
         if (kind < 80) begin
            stride = (step_now == 0) ? 1 : step_now;
            ticks = $urandom_range(2, 360 / stride + 6);
            if (ticks > 40)
               ticks = 40;
            run_move(pick_angle(), pick_angle(), pick_angle(), 1'($urandom_range(1)), ticks);
            sent += 1 + ticks;
         end else if (kind < 90) begin
            send_tick();
            sent++;
         end else begin
            send_beat(OP_LOAD, pick_angle(), pick_angle(), pick_angle(),
                      1'($urandom_range(1)));
            sent++;
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      idle_mode = 2;

      // Directed: idle tick, saturated targets, negative PWM span, gripper past 180,
      // gripper already at its limit, step of zero and a write to an unmapped index.
      send_tick();
      settle();
      write_reg(CSR_STEP_SIZE, 12'd30);
      run_move(8'd255, 8'd0, 8'd180, 1'b1, 9);
      settle();
      write_reg(CSR_PWM_MIN, 12'd4095);
      write_reg(CSR_PWM_MAX, 12'd0);
      write_reg(CSR_GRIP_CLOSE, 12'd250);
      run_move(8'd180, 8'd0, 8'd160, 1'b1, 7);
      settle();
      run_move(8'd180, 8'd0, 8'd160, 1'b0, 2);
      settle();
      write_reg(CSR_GRIP_OPEN, 12'd250);
      send_tick();
      settle();
      write_reg(CSR_STEP_SIZE, 12'd0);
      write_reg(CSR_SPARE_LO + 3'd2, 12'hFFF);
      run_move(8'd180, 8'd1, 8'd160, 1'b0, 2);
      settle();

      idle_mode = 0;
      configure($urandom_range(5, 30), $urandom_range(4095), $urandom_range(4095),
                $urandom_range(60, 180), $urandom_range(0, 90));
      random_phase(105);
      settle();

      idle_mode = 1;
      configure($urandom_range(1, 31), 0, 4095, int'(ANGLE_MAX), 0);
      random_phase(105);
      settle();

      idle_mode = 2;
      configure($urandom_range(3, 30), 4095, 0, $urandom_range(255), $urandom_range(255));
      hold_request = 1'b1;
      random_phase(110);
      settle();

      $display("Drove %0d loads and %0d ticks with %0d register writes, under three stall patterns",
               loads_sent, ticks_sent, reg_writes);
      $display("and one long output hold; %0d result beats compared, %0d mismatches.",
               results_checked, mismatches);
      if (mismatches == 0)
         $display("[servo_ramp_stepper] OK");
      else
         $display("[servo_ramp_stepper] ERROR");
      $finish;
   end

endmodule
